FILE: rtl/core/mhpq_pkg.sv
// Shared definitions for the max-heap priority queue core.
// Holds the capacity, address and key types, kind and status codes, the store request and the sequencer states.
// Depends on nothing.
package mhpq_pkg;

   localparam int CAPACITY = 255;
   localparam int ADDR_W   = $clog2(CAPACITY + 1);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [ADDR_W:0]   kid_type;
   typedef logic signed [31:0] key_type;

   localparam addr_type ROOT_ADDR = addr_type'(1);
   localparam addr_type CAP_COUNT = addr_type'(CAPACITY);

   localparam logic       KIND_INSERT  = 1'b0;
   localparam logic       KIND_REMOVE  = 1'b1;
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      key_type  wr_data;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_CMP,
      ST_UP_FINAL,
      ST_DN_TOP,
      ST_DN_LAST,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_CMP,
      ST_DN_FINAL
   } state_type;

endpackage

FILE: rtl/core/mhpq_store.sv
// Key store of the heap: one write port and one read port with registered read data.
// Depends on mhpq_pkg.
module mhpq_store
   import mhpq_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output key_type     rd_data
);

   key_type mem_ff [1:CAPACITY];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/max_heap_priority_queue_core.sv
// Max-heap priority queue: one beat in, one beat out per item, one item at a time.
// An insert writes the first key straight to the root; otherwise the key rises one level per
// compare that it wins against its parent. A removal reads the root and the last key, then
// moves that key down, comparing the children of each level; the steps are set by the single
// store read port and the one shared key comparator. Refused items are answered from idle.
// Synchronous reset empties the queue; the key store itself is not cleared.
module max_heap_priority_queue_core
   import mhpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  key_type     req_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output key_type     rsp_max_key,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_count
);

   state_type   state_ff, state_in;
   addr_type    count_ff, count_in;
   addr_type    pos_ff, pos_in;
   kid_type     kid_ff, kid_in;
   key_type     key_ff, key_in;
   key_type     top_ff, top_in;
   key_type     best_ff, best_in;
   logic        rsp_valid_ff, rsp_valid_in;
   key_type     rsp_max_key_ff, rsp_max_key_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_count_ff, rsp_count_in;

   mem_req_type mem_req;
   key_type     rd_data;
   key_type     cmp_a, cmp_b;
   logic        cmp_gt;
   addr_type    new_pos;
   kid_type     kid_next;

   mhpq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign cmp_gt = cmp_a > cmp_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff         <= pos_in;
      kid_ff         <= kid_in;
      key_ff         <= key_in;
      top_ff         <= top_in;
      best_ff        <= best_in;
      rsp_max_key_ff <= rsp_max_key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      kid_in         = kid_ff;
      key_in         = key_ff;
      top_in         = top_ff;
      best_in        = best_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_max_key_in = rsp_max_key_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      mem_req        = '0;
      cmp_a          = key_ff;
      cmp_b          = rd_data;
      req_ready      = 1'b0;
      new_pos        = pos_ff >> 1;
      kid_next       = kid_ff << 1;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               if (req_kind == KIND_INSERT) begin
                  if (count_ff >= CAP_COUNT) begin
                     rsp_valid_in   = 1'b1;
                     rsp_max_key_in = '0;
                     rsp_status_in  = STATUS_FULL;
                     rsp_count_in   = 8'(count_ff);
                  end else begin
                     count_in = count_ff + addr_type'(1);
                     key_in   = req_key;
                     pos_in   = count_ff + addr_type'(1);
                     if (count_ff == '0) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ROOT_ADDR;
                        mem_req.wr_data = req_key;
                        rsp_valid_in    = 1'b1;
                        rsp_max_key_in  = '0;
                        rsp_status_in   = STATUS_OK;
                        rsp_count_in    = 8'(count_ff + addr_type'(1));
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = (count_ff + addr_type'(1)) >> 1;
                        state_in        = ST_UP_CMP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in   = 1'b1;
                     rsp_max_key_in = '0;
                     rsp_status_in  = STATUS_EMPTY;
                     rsp_count_in   = 8'(count_ff);
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = ROOT_ADDR;
                     state_in        = ST_DN_TOP;
                  end
               end
            end
         end

         ST_UP_CMP: begin
            cmp_a = key_ff;
            cmp_b = rd_data;
            if (cmp_gt) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = rd_data;
               pos_in          = new_pos;
               if (new_pos == ROOT_ADDR) begin
                  state_in = ST_UP_FINAL;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = new_pos >> 1;
               end
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = key_ff;
               rsp_valid_in    = 1'b1;
               rsp_max_key_in  = '0;
               rsp_status_in   = STATUS_OK;
               rsp_count_in    = 8'(count_ff);
               state_in        = ST_IDLE;
            end
         end

         ST_UP_FINAL: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            mem_req.wr_data = key_ff;
            rsp_valid_in    = 1'b1;
            rsp_max_key_in  = '0;
            rsp_status_in   = STATUS_OK;
            rsp_count_in    = 8'(count_ff);
            state_in        = ST_IDLE;
         end

         ST_DN_TOP: begin
            top_in          = rd_data;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = count_ff;
            count_in        = count_ff - addr_type'(1);
            state_in        = ST_DN_LAST;
         end

         ST_DN_LAST: begin
            key_in = rd_data;
            pos_in = ROOT_ADDR;
            kid_in = kid_type'(2);
            if (kid_type'(2) > kid_type'(count_ff)) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ROOT_ADDR;
               mem_req.wr_data = rd_data;
               rsp_valid_in    = 1'b1;
               rsp_max_key_in  = top_ff;
               rsp_status_in   = STATUS_OK;
               rsp_count_in    = 8'(count_ff);
               state_in        = ST_IDLE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = addr_type'(2);
               state_in        = ST_DN_LEFT;
            end
         end

         ST_DN_LEFT: begin
            best_in = rd_data;
            if (kid_ff < kid_type'(count_ff)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = kid_ff[ADDR_W-1:0] + addr_type'(1);
               state_in        = ST_DN_RIGHT;
            end else begin
               state_in = ST_DN_CMP;
            end
         end

         ST_DN_RIGHT: begin
            cmp_a = rd_data;
            cmp_b = best_ff;
            if (cmp_gt) begin
               best_in = rd_data;
               kid_in  = kid_ff + kid_type'(1);
            end
            state_in = ST_DN_CMP;
         end

         ST_DN_CMP: begin
            cmp_a = best_ff;
            cmp_b = key_ff;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            if (!cmp_gt) begin
               mem_req.wr_data = key_ff;
               rsp_valid_in    = 1'b1;
               rsp_max_key_in  = top_ff;
               rsp_status_in   = STATUS_OK;
               rsp_count_in    = 8'(count_ff);
               state_in        = ST_IDLE;
            end else begin
               mem_req.wr_data = best_ff;
               pos_in          = kid_ff[ADDR_W-1:0];
               kid_in          = kid_next;
               if (kid_next > kid_type'(count_ff)) begin
                  state_in = ST_DN_FINAL;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = kid_next[ADDR_W-1:0];
                  state_in        = ST_DN_LEFT;
               end
            end
         end

         ST_DN_FINAL: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            mem_req.wr_data = key_ff;
            rsp_valid_in    = 1'b1;
            rsp_max_key_in  = top_ff;
            rsp_status_in   = STATUS_OK;
            rsp_count_in    = 8'(count_ff);
            state_in        = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_max_key = rsp_max_key_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_count   = rsp_count_ff;

endmodule

FILE: verif/max_heap_priority_queue_checker.sv
// Checker for the max-heap priority queue core: watches the request and response channels,
// keeps its own copy of the heap and compares every response beat with the predicted one.
// Depends on mhpq_pkg for the key type, the capacity and the kind and status codes.
module max_heap_priority_queue_checker
   import mhpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  key_type     req_key,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  key_type     rsp_max_key,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_count,
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      key_type     max_key;
      logic [1:0]  status;
      logic [7:0]  count;
   } reply_type;

   key_type     heap_keys [1:CAPACITY];
   int unsigned held;
   reply_type   pending_replies [$];

   function automatic reply_type heap_apply(logic kind, key_type key);
      reply_type   r;
      int unsigned pos;
      int unsigned hole;
      int unsigned kid;
      key_type     moved;
      r = '{max_key: '0, status: STATUS_OK, count: '0};
      if (kind == KIND_INSERT) begin
         if (held >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            held++;
            pos = held;
            while (pos != 1 && key > heap_keys[pos / 2]) begin
               heap_keys[pos] = heap_keys[pos / 2];
               pos = pos / 2;
            end
            heap_keys[pos] = key;
         end
      end else begin
         if (held == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.max_key = heap_keys[1];
            moved = heap_keys[held];
            held--;
            hole = 1;
            kid = 2;
            while (kid <= held) begin
               if (kid < held && heap_keys[kid + 1] > heap_keys[kid]) begin
                  kid++;
               end
               if (moved >= heap_keys[kid]) begin
                  break;
               end
               heap_keys[hole] = heap_keys[kid];
               hole = kid;
               kid = kid * 2;
            end
            heap_keys[hole] = moved;
         end
      end
      r.count = 8'(held);
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         held = 0;
         pending_replies.delete();
         mismatches = 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected response beat: max_key %0d status %0d count %0d",
                           rsp_max_key, rsp_status, rsp_count);
               end
            end else begin
               want = pending_replies.pop_front();
               if (rsp_max_key !== want.max_key || rsp_status !== want.status ||
                   rsp_count !== want.count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("response mismatch: expected max_key %0d status %0d count %0d, %s",
                              want.max_key, want.status, want.count,
                              $sformatf("got max_key %0d status %0d count %0d",
                                        rsp_max_key, rsp_status, rsp_count));
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_replies.push_back(heap_apply(req_kind, req_key));
         end
         outstanding <= pending_replies.size();
      end
   end

endmodule

FILE: verif/tb.sv
// Top of the max-heap priority queue testbench: clock, reset, request stimulus and response
// back-pressure around the core, with the checker beside it and the final verdict.
// Depends on mhpq_pkg, max_heap_priority_queue_core and max_heap_priority_queue_checker.
module tb;
   import mhpq_pkg::*;

   localparam int ITEM_TARGET = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_INSERT;
   key_type     req_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   key_type     rsp_max_key;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_count;
   int          mismatches;
   int          outstanding;

   logic        hold_wanted = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;
   int          pattern_left = 0;
   int          pattern_mode = 0;
   int          idle_cycles = 0;

   int          sent = 0;
   int          level = 0;
   int          burst_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   max_heap_priority_queue_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_key     (req_key),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_max_key (rsp_max_key),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count)
   );

   max_heap_priority_queue_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_key     (req_key),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_max_key (rsp_max_key),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // The long hold-off is served once on request; otherwise the stall pattern picks a new mode
   // each time its random run length is used up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_wanted && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (pattern_left == 0) begin
         pattern_mode <= $urandom_range(0, 3);
         pattern_left <= $urandom_range(20, 200);
         rsp_ready <= 1'b1;
      end else begin
         pattern_left <= pattern_left - 1;
         case (pattern_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= pattern_left[3];
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no beat accepted for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic key_type pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return key_type'($urandom);
         5, 6: return key_type'($urandom_range(0, 8)) - key_type'(4);
         7: return key_type'(32'h7FFF_FFFF - $urandom_range(0, 3));
         8: return key_type'(32'h8000_0000 + $urandom_range(0, 3));
         default: return $urandom_range(0, 1) ? key_type'(32'h7FFF_FFFF)
                                               : key_type'(32'h8000_0000);
      endcase
   endfunction

   task automatic offer(input logic kind, input key_type key);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_key   <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind == KIND_INSERT && level < CAPACITY) begin
         level++;
      end else if (kind == KIND_REMOVE && level > 0) begin
         level--;
      end
      sent++;
   endtask

   initial begin
      int phase;
      int phase_len;
      int remove_odds;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      offer(KIND_REMOVE, key_type'(32'hFFFF_FFFF));
      offer(KIND_INSERT, key_type'(0));
      offer(KIND_INSERT, key_type'(32'h7FFF_FFFF));
      offer(KIND_INSERT, key_type'(32'h8000_0000));
      offer(KIND_INSERT, key_type'(-1));
      offer(KIND_INSERT, key_type'(1));
      offer(KIND_INSERT, key_type'(32'h7FFF_FFFF));
      offer(KIND_INSERT, key_type'(32'h8000_0000));
      repeat (8) offer(KIND_REMOVE, key_type'(0));
      repeat (4) offer(KIND_INSERT, key_type'(3));
      offer(KIND_INSERT, key_type'(9));
      repeat (5) offer(KIND_REMOVE, key_type'($urandom));

      // Fill to capacity, starting with the long receiver hold-off, so that the core backs up its input.
      hold_wanted <= 1'b1;
      while (level < CAPACITY) offer(KIND_INSERT, pick_key());
      repeat (3) offer(KIND_INSERT, pick_key());
      while (level > 0) offer(KIND_REMOVE, key_type'($urandom));
      repeat (2) offer(KIND_REMOVE, key_type'($urandom));

      while (sent < ITEM_TARGET) begin
         phase = $urandom_range(0, 2);
         phase_len = $urandom_range(30, 120);
         case (phase)
            0: remove_odds = 50;
            1: remove_odds = 25;
            default: remove_odds = 75;
         endcase
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < remove_odds) begin
               offer(KIND_REMOVE, key_type'($urandom));
            end else begin
               offer(KIND_INSERT, pick_key());
            end
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_store.sv
rtl/core/max_heap_priority_queue_core.sv
verif/max_heap_priority_queue_checker.sv
verif/tb.sv
